@@ hdl/gps_pkg.sv @@
// Shared constants, types and the sine gain table for the granular pitch shifter.
package gps_pkg;

	localparam int HISTORY_DEPTH_DEF = 8192;
	localparam int SAMPLE_BITS_DEF   = 24;

	localparam int RATIO_W  = 18;
	localparam int MIX_W    = 16;
	localparam int WIN_W    = 13;
	localparam int FRAC_W   = 16;
	localparam int DELAY_W  = WIN_W + FRAC_W;
	localparam int PHASE_W  = 16;
	localparam int GAIN_W   = 16;
	localparam int REM_W    = WIN_W + 1;

	localparam int RATIO_MIN = 32768;
	localparam int RATIO_MAX = 131072;
	localparam int MIX_MAX   = 32768;
	localparam int WIN_MIN   = 256;
	localparam int WIN_GUARD = 200;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_RATE_RATIO    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_LEVEL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_ENABLE = 3'd3;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd65536;
	localparam logic [MIX_W-1:0]   MIX_RESET   = 16'd32768;
	localparam logic [WIN_W-1:0]   WIN_RESET   = 13'd2400;

	// quarter wave of sin, Q1.15
	localparam logic [15:0] QSINE [0:64] = '{
		16'd0, 16'd804, 16'd1608, 16'd2411, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
		16'd6393, 16'd7180, 16'd7962, 16'd8740, 16'd9512, 16'd10279, 16'd11039,
		16'd11793, 16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151,
		16'd16846, 16'd17531, 16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788,
		16'd21403, 16'd22006, 16'd22595, 16'd23170, 16'd23732, 16'd24279, 16'd24812,
		16'd25330, 16'd25833, 16'd26320, 16'd26791, 16'd27246, 16'd27684, 16'd28106,
		16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957, 16'd30274, 16'd30572,
		16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972, 16'd32138,
		16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
		16'd32768
	};

	typedef struct packed {
		logic               start;
		logic [DELAY_W-1:0] dividend;
		logic [WIN_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [PHASE_W-1:0] quot;
		logic [WIN_W-1:0]   rem_hi;
	} div_rsp_t;

	// sin(pi*q/65536): fold to a quarter wave, interpolate over 9 fraction bits
	function automatic logic [GAIN_W-1:0] sine_gain(input logic [PHASE_W-1:0] q);
		logic [16:0] u;
		logic [6:0]  i;
		logic [8:0]  f;
		logic [15:0] t0;
		logic [15:0] t1;
		logic [24:0] p;
		logic [GAIN_W-1:0] g;
		u = q[15] ? (17'd65536 - {1'b0, q}) : {1'b0, q};
		i = u[15:9];
		f = u[8:0];
		if (u[16] || i[6]) begin
			g = QSINE[64];
		end else begin
			t0 = QSINE[i];
			t1 = QSINE[i + 7'd1];
			p = 25'(t1 - t0) * 25'(f);
			g = t0 + 16'(p >> 9);
		end
		return g;
	endfunction

endpackage

@@ hdl/gps_in_if.sv @@
// Input sample channel: valid/ready with one stereo sample.
interface gps_in_if #(parameter int SB = gps_pkg::SAMPLE_BITS_DEF) ();
	logic                 valid;
	logic                 ready;
	logic signed [SB-1:0] left_in;
	logic signed [SB-1:0] right_in;
	modport source (output valid, left_in, right_in, input ready);
	modport sink (input valid, left_in, right_in, output ready);
endinterface

@@ hdl/gps_out_if.sv @@
// Output sample channel: valid/ready with one stereo result.
interface gps_out_if #(parameter int SB = gps_pkg::SAMPLE_BITS_DEF) ();
	logic                 valid;
	logic                 ready;
	logic signed [SB-1:0] left_out;
	logic signed [SB-1:0] right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

@@ hdl/gps_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface gps_cfg_if ();
	logic                            valid;
	logic                            ready;
	logic [gps_pkg::CFG_IDX_W-1:0]  index;
	logic [gps_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/gps_divider.sv @@
// Radix-256 restoring divider of the read delay by the window length.
module gps_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  gps_pkg::div_req_t req,
	output gps_pkg::div_rsp_t rsp
);
	localparam int STEP = 8;

	logic                         busy_q;
	logic [1:0]                   cnt_q;
	logic [31:0]                  dvd_q;
	logic [gps_pkg::WIN_W-1:0]    dvs_q;
	logic [gps_pkg::REM_W-1:0]    rem_q;
	logic [gps_pkg::PHASE_W-1:0]  quo_q;
	logic [gps_pkg::WIN_W-1:0]    rhi_q;
	logic                         done_q;

	logic [gps_pkg::REM_W-1:0] rem_n;
	logic [STEP-1:0]           qb_n;

	always_comb begin
		logic [gps_pkg::REM_W-1:0] r;
		r = rem_q;
		qb_n = '0;
		for (int k = 0; k < STEP; k++) begin
			r = {r[gps_pkg::REM_W-2:0], dvd_q[31-k]};
			if (r >= {1'b0, dvs_q}) begin
				r = r - {1'b0, dvs_q};
				qb_n[STEP-1-k] = 1'b1;
			end
		end
		rem_n = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= 32'(req.dividend);
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << STEP;
			rem_q <= rem_n;
			quo_q <= {quo_q[gps_pkg::PHASE_W-STEP-1:0], qb_n};
			// after the upper 16 dividend bits the remainder is the whole-sample delay mod W
			if (cnt_q == 2'd1) begin
				rhi_q <= rem_n[gps_pkg::WIN_W-1:0];
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quot   = quo_q;
	assign rsp.rem_hi = rhi_q;
endmodule

@@ hdl/granular_pitch_shifter.sv @@
// Granular pitch shifter: one stereo sample in, one out; in bypass the input goes straight out.
// A sample runs through the divider, address, two read, tap, wet, mix and final states.
// One sample is in work at a time; the 4-step delay divider and the two read passes
// over the history memories set the rate. A waiting result does not block acceptance;
// it holds the next sample in its final state until the output register frees up.
// Reset clears control state; history entries not yet written since reset read as zero
// through a fill tracker, so no clearing pass is needed.
module granular_pitch_shifter #(
	parameter int HISTORY_DEPTH = gps_pkg::HISTORY_DEPTH_DEF,
	parameter int SAMPLE_BITS   = gps_pkg::SAMPLE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gps_in_if.sink     in_ch,
	gps_out_if.source  out_ch,
	gps_cfg_if.sink    cfg_ch
);
	localparam int SB = SAMPLE_BITS;
	localparam int IB = $clog2(HISTORY_DEPTH);
	localparam int PB = IB + gps_pkg::FRAC_W;
	localparam int DW = gps_pkg::DELAY_W;
	localparam int WIN_LIM = HISTORY_DEPTH - gps_pkg::WIN_GUARD;
	localparam int WIN_MAX = (WIN_LIM < 8191) ? WIN_LIM : 8191;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_ADDR = 4'd2;
	localparam logic [3:0] S_RD1  = 4'd3;
	localparam logic [3:0] S_RD2  = 4'd4;
	localparam logic [3:0] S_TAP2 = 4'd5;
	localparam logic [3:0] S_WET  = 4'd6;
	localparam logic [3:0] S_MIX  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;
	localparam logic [3:0] S_BYP  = 4'd9;

	localparam logic signed [SB+5:0] SMAX = (SB+6)'((64'sd1 <<< (SB-1)) - 64'sd1);
	localparam logic signed [SB+5:0] SMIN = -SMAX - (SB+6)'(1);

	// configuration
	logic [gps_pkg::RATIO_W-1:0] ratio_q;
	logic [gps_pkg::MIX_W-1:0]   mix_q;
	logic [gps_pkg::WIN_W-1:0]   win_q;
	logic                        bypass_q;

	// control
	logic [3:0]    state_q;
	logic [IB-1:0] wi_q;
	logic          wrapped_q;
	logic [DW-1:0] rd_q;
	logic          out_valid_q;

	gps_pkg::div_req_t div_req;
	gps_pkg::div_rsp_t div_rsp;

	// payload
	logic signed [SB-1:0] l_q, r_q;
	logic [gps_pkg::GAIN_W-1:0] g1_s1, g2_s1;
	logic [IB-1:0] a0_1_s1, a1_1_s1, a0_2_s1, a1_2_s1;
	logic [gps_pkg::FRAC_W-1:0] f1_s1, f2_s1;
	logic [DW-1:0] rd_next_s1;
	logic signed [SB-1:0] mla_q, mlb_q, mra_q, mrb_q;
	logic va_q, vb_q;
	logic signed [SB-1:0] t1l_s2, t1r_s2, t2l_s2, t2r_s2;
	logic signed [SB+1:0] wetl_s3, wetr_s3;
	logic signed [SB+19:0] mxl_s4, mxr_s4;
	logic signed [SB-1:0] outl_q, outr_q;

	logic signed [SB-1:0] mem_l [HISTORY_DEPTH];
	logic signed [SB-1:0] mem_r [HISTORY_DEPTH];

	logic in_acc, slot_free, out_load;
	logic [gps_pkg::WIN_W-1:0]   w_c;
	logic [gps_pkg::RATIO_W-1:0] rate_c;
	logic [gps_pkg::MIX_W-1:0]   mix_c;
	logic [DW-1:0] wf_c;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = (state_q == S_IDLE);
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign slot_free    = !out_valid_q || out_ch.ready;
	assign out_load     = ((state_q == S_FIN) || (state_q == S_BYP)) && slot_free;

	assign out_ch.valid     = out_valid_q;
	assign out_ch.left_out  = outl_q;
	assign out_ch.right_out = outr_q;

	always_comb begin
		if (win_q > gps_pkg::WIN_W'(WIN_MAX)) w_c = gps_pkg::WIN_W'(WIN_MAX);
		else if (win_q < gps_pkg::WIN_W'(gps_pkg::WIN_MIN)) w_c = gps_pkg::WIN_W'(gps_pkg::WIN_MIN);
		else w_c = win_q;
		if (ratio_q < gps_pkg::RATIO_W'(gps_pkg::RATIO_MIN)) rate_c = gps_pkg::RATIO_W'(gps_pkg::RATIO_MIN);
		else if (ratio_q > gps_pkg::RATIO_W'(gps_pkg::RATIO_MAX)) rate_c = gps_pkg::RATIO_W'(gps_pkg::RATIO_MAX);
		else rate_c = ratio_q;
		mix_c = (mix_q > gps_pkg::MIX_W'(gps_pkg::MIX_MAX)) ? gps_pkg::MIX_W'(gps_pkg::MIX_MAX) : mix_q;
		wf_c = {w_c, 16'b0};
	end

	assign div_req.start    = in_acc && !bypass_q;
	assign div_req.dividend = rd_q;
	assign div_req.divisor  = w_c;

	gps_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// tap positions, gains and next delay from the divider result
	logic [DW-1:0] d1_c, d2_c, nd_c;
	logic [DW:0]   d2x_c;
	logic signed [DW+1:0] ndx_c;
	logic [gps_pkg::PHASE_W-1:0] q1_c, q2_c;
	logic [PB-1:0] p1_c, p2_c;

	always_comb begin
		d1_c  = {div_rsp.rem_hi, rd_q[gps_pkg::FRAC_W-1:0]};
		d2x_c = {1'b0, d1_c} + (DW+1)'({w_c, 15'b0});
		if (d2x_c >= {1'b0, wf_c}) d2x_c = d2x_c - {1'b0, wf_c};
		d2_c  = d2x_c[DW-1:0];
		q1_c  = div_rsp.quot;
		q2_c  = {~q1_c[15], q1_c[14:0]};
		p1_c  = {wi_q, 16'b0} - PB'(d1_c);
		p2_c  = {wi_q, 16'b0} - PB'(d2_c);
		ndx_c = $signed({2'b0, d1_c}) + (DW+2)'(65536) - $signed((DW+2)'(rate_c));
		if (ndx_c < 0) ndx_c = ndx_c + $signed({2'b0, wf_c});
		else if (ndx_c >= $signed({2'b0, wf_c})) ndx_c = ndx_c - $signed({2'b0, wf_c});
		nd_c  = ndx_c[DW-1:0];
	end

	// memory read ports
	logic          rd_en;
	logic [IB-1:0] ra_c, rb_c;
	assign rd_en = (state_q == S_RD1) || (state_q == S_RD2);
	assign ra_c  = (state_q == S_RD1) ? a0_1_s1 : a0_2_s1;
	assign rb_c  = (state_q == S_RD1) ? a1_1_s1 : a1_2_s1;

	always_ff @(posedge clk) begin
		if (in_acc && !bypass_q) begin
			mem_l[wi_q] <= in_ch.left_in;
			mem_r[wi_q] <= in_ch.right_in;
		end
		if (rd_en) begin
			mla_q <= mem_l[ra_c];
			mlb_q <= mem_l[rb_c];
			mra_q <= mem_r[ra_c];
			mrb_q <= mem_r[rb_c];
			va_q  <= wrapped_q || (ra_c <= wi_q);
			vb_q  <= wrapped_q || (rb_c <= wi_q);
		end
	end

	// linear interpolation, shared by both taps
	logic [gps_pkg::FRAC_W-1:0] tf_c;
	logic [gps_pkg::FRAC_W:0]   tw_c;
	logic signed [SB-1:0] s0l, s1l, s0r, s1r;
	logic signed [SB+18:0] tsl_c, tsr_c;
	always_comb begin
		tf_c = (state_q == S_RD2) ? f1_s1 : f2_s1;
		tw_c = 17'd65536 - {1'b0, tf_c};
		s0l = va_q ? mla_q : '0;
		s1l = vb_q ? mlb_q : '0;
		s0r = va_q ? mra_q : '0;
		s1r = vb_q ? mrb_q : '0;
		tsl_c = s0l * $signed({1'b0, tw_c}) + s1l * $signed({2'b0, tf_c}) + (SB+19)'(32768);
		tsr_c = s0r * $signed({1'b0, tw_c}) + s1r * $signed({2'b0, tf_c}) + (SB+19)'(32768);
	end

	// crossfade sum
	logic signed [SB+17:0] wsl_c, wsr_c;
	always_comb begin
		wsl_c = t1l_s2 * $signed({1'b0, g1_s1}) + t2l_s2 * $signed({1'b0, g2_s1})
			+ (SB+18)'(16384);
		wsr_c = t1r_s2 * $signed({1'b0, g1_s1}) + t2r_s2 * $signed({1'b0, g2_s1})
			+ (SB+18)'(16384);
	end

	// dry/wet blend and saturation
	logic signed [SB+2:0]  dfl_c, dfr_c;
	logic signed [SB+19:0] rnl_c, rnr_c;
	logic signed [SB+5:0]  sml_c, smr_c;
	logic signed [SB-1:0]  stl_c, str_c;
	always_comb begin
		dfl_c = wetl_s3 - l_q;
		dfr_c = wetr_s3 - r_q;
		rnl_c = mxl_s4 + (SB+20)'(16384);
		rnr_c = mxr_s4 + (SB+20)'(16384);
		sml_c = l_q + $signed(rnl_c[SB+19:15]);
		smr_c = r_q + $signed(rnr_c[SB+19:15]);
		if (sml_c > SMAX) stl_c = SMAX[SB-1:0];
		else if (sml_c < SMIN) stl_c = SMIN[SB-1:0];
		else stl_c = sml_c[SB-1:0];
		if (smr_c > SMAX) str_c = SMAX[SB-1:0];
		else if (smr_c < SMIN) str_c = SMIN[SB-1:0];
		else str_c = smr_c[SB-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			l_q <= in_ch.left_in;
			r_q <= in_ch.right_in;
		end
		if (state_q == S_ADDR) begin
			g1_s1      <= gps_pkg::sine_gain(q1_c);
			g2_s1      <= gps_pkg::sine_gain(q2_c);
			a0_1_s1    <= p1_c[PB-1:16];
			a1_1_s1    <= p1_c[PB-1:16] + IB'(1);
			a0_2_s1    <= p2_c[PB-1:16];
			a1_2_s1    <= p2_c[PB-1:16] + IB'(1);
			f1_s1      <= p1_c[15:0];
			f2_s1      <= p2_c[15:0];
			rd_next_s1 <= nd_c;
		end
		if (state_q == S_RD2) begin
			t1l_s2 <= tsl_c[SB+15:16];
			t1r_s2 <= tsr_c[SB+15:16];
		end
		if (state_q == S_TAP2) begin
			t2l_s2 <= tsl_c[SB+15:16];
			t2r_s2 <= tsr_c[SB+15:16];
		end
		if (state_q == S_WET) begin
			wetl_s3 <= wsl_c[SB+16:15];
			wetr_s3 <= wsr_c[SB+16:15];
		end
		if (state_q == S_MIX) begin
			mxl_s4 <= dfl_c * $signed({1'b0, mix_c});
			mxr_s4 <= dfr_c * $signed({1'b0, mix_c});
		end
		if (out_load) begin
			outl_q <= (state_q == S_BYP) ? l_q : stl_c;
			outr_q <= (state_q == S_BYP) ? r_q : str_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q     <= gps_pkg::RATIO_RESET;
			mix_q       <= gps_pkg::MIX_RESET;
			win_q       <= gps_pkg::WIN_RESET;
			bypass_q    <= 1'b0;
			state_q     <= S_IDLE;
			wi_q        <= '0;
			wrapped_q   <= 1'b0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					gps_pkg::CFG_RATE_RATIO:    ratio_q  <= cfg_ch.data[gps_pkg::RATIO_W-1:0];
					gps_pkg::CFG_MIX_LEVEL:     mix_q    <= cfg_ch.data[gps_pkg::MIX_W-1:0];
					gps_pkg::CFG_WINDOW_LENGTH: win_q    <= cfg_ch.data[gps_pkg::WIN_W-1:0];
					gps_pkg::CFG_BYPASS_ENABLE: bypass_q <= cfg_ch.data[0];
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= bypass_q ? S_BYP : S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) state_q <= S_ADDR;
				end
				S_ADDR: state_q <= S_RD1;
				S_RD1:  state_q <= S_RD2;
				S_RD2:  state_q <= S_TAP2;
				S_TAP2: state_q <= S_WET;
				S_WET:  state_q <= S_MIX;
				S_MIX:  state_q <= S_FIN;
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
						rd_q    <= rd_next_s1;
						wi_q    <= wi_q + IB'(1);
						if (&wi_q) wrapped_q <= 1'b1;
					end
				end
				S_BYP: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ch.ready))
		else $error("result overwritten");

	// divider finishes only while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("stray divider completion");

	// stored delay stays inside the window it was computed for
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && slot_free) |=> (rd_q < $past(wf_c)))
		else $error("read delay out of window");
endmodule

@@ dv/tb_granular_pitch_shifter.sv @@
// Testbench for the granular pitch shifter: predicted stereo results checked against the block.
module tb_granular_pitch_shifter;

	localparam int DEPTH = gps_pkg::HISTORY_DEPTH_DEF;
	localparam int SB = gps_pkg::SAMPLE_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int CW = gps_pkg::CFG_DATA_W;

	typedef struct {
		logic signed [SB-1:0] left;
		logic signed [SB-1:0] right;
	} stereo_t;

	// Predicts the shifter's output and holds the results still owed by the block.
	class shift_scoreboard;
		logic signed [SB-1:0] hist_l [DEPTH];
		logic signed [SB-1:0] hist_r [DEPTH];
		int unsigned wr_idx;
		longint unsigned delay;
		longint unsigned ratio, mix, win, bypass;
		stereo_t owed [$];
		int errors;
		int checked;

		function void clear();
			foreach (hist_l[k]) begin
				hist_l[k] = '0;
				hist_r[k] = '0;
			end
			wr_idx = 0;
			delay = 0;
			ratio = 65536;
			mix = 32768;
			win = 2400;
			bypass = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [gps_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] d);
			case (idx)
				gps_pkg::CFG_RATE_RATIO: ratio = d;
				gps_pkg::CFG_MIX_LEVEL: mix = d[gps_pkg::MIX_W-1:0];
				gps_pkg::CFG_WINDOW_LENGTH: win = d[gps_pkg::WIN_W-1:0];
				gps_pkg::CFG_BYPASS_ENABLE: bypass = d[0];
				default: ;
			endcase
		endfunction

		function longint floor_sh(longint v, int s);
			return v >>> s;
		endfunction

		function longint round_sh(longint v, int s);
			return (v + (64'sd1 <<< (s - 1))) >>> s;
		endfunction

		function longint gain_of(longint unsigned q);
			longint unsigned u;
			longint unsigned i;
			longint unsigned f;
			longint t0;
			longint t1;
			u = q & 16'hFFFF;
			if (u >= 32768) u = 65536 - u;
			i = u >> 9;
			f = u & 511;
			if (i >= 64) return gps_pkg::QSINE[64];
			t0 = gps_pkg::QSINE[i];
			t1 = gps_pkg::QSINE[i + 1];
			return t0 + floor_sh((t1 - t0) * longint'(f), 9);
		endfunction

		function longint interp(bit right_side, longint unsigned pos);
			int unsigned i0;
			int unsigned i1;
			longint f;
			longint s0;
			longint s1;
			i0 = (pos >> 16) % DEPTH;
			i1 = (i0 + 1) % DEPTH;
			f = pos & 16'hFFFF;
			s0 = right_side ? hist_r[i0] : hist_l[i0];
			s1 = right_side ? hist_r[i1] : hist_l[i1];
			return round_sh(s0 * (65536 - f) + s1 * f, 16);
		endfunction

		function longint sat(longint v);
			longint hi;
			hi = (64'sd1 <<< (SB - 1)) - 1;
			return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
		endfunction

		function void note_request(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
			stereo_t res;
			longint unsigned w, wf, rt, m, d1, d2, p1, p2, dep;
			longint g1, g2, wl, wr, nd, ll, rr;
			ll = l;
			rr = r;
			if (bypass) begin
				res.left = l;
				res.right = r;
				owed.push_back(res);
				return;
			end
			w = win;
			if (w > DEPTH - gps_pkg::WIN_GUARD) w = DEPTH - gps_pkg::WIN_GUARD;
			if (w < gps_pkg::WIN_MIN) w = gps_pkg::WIN_MIN;
			wf = w << 16;
			rt = ratio;
			if (rt < gps_pkg::RATIO_MIN) rt = gps_pkg::RATIO_MIN;
			if (rt > gps_pkg::RATIO_MAX) rt = gps_pkg::RATIO_MAX;
			m = mix > gps_pkg::MIX_MAX ? gps_pkg::MIX_MAX : mix;
			hist_l[wr_idx] = l;
			hist_r[wr_idx] = r;
			d1 = delay % wf;
			d2 = d1 + (w << 15);
			if (d2 >= wf) d2 -= wf;
			g1 = gain_of((d1 << 16) / wf);
			g2 = gain_of((d2 << 16) / wf);
			dep = longint'(DEPTH) << 16;
			p1 = ((longint'(wr_idx) << 16) + dep - d1) % dep;
			p2 = ((longint'(wr_idx) << 16) + dep - d2) % dep;
			wl = round_sh(g1 * interp(0, p1) + g2 * interp(0, p2), 15);
			wr = round_sh(g1 * interp(1, p1) + g2 * interp(1, p2), 15);
			res.left = SB'(sat(ll + round_sh((wl - ll) * longint'(m), 15)));
			res.right = SB'(sat(rr + round_sh((wr - rr) * longint'(m), 15)));
			nd = longint'(d1) + 65536 - longint'(rt);
			if (nd < 0) nd += longint'(wf);
			delay = longint'(nd) % wf;
			wr_idx = (wr_idx + 1) % DEPTH;
			owed.push_back(res);
		endfunction

		function void check_result(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
			stereo_t e;
			if (owed.size() == 0) begin
				$error("unexpected result left=%0d right=%0d", l, r);
				errors++;
				return;
			end
			e = owed.pop_front();
			checked++;
			if (l !== e.left) begin
				$error("left_out mismatch: expected %0d actual %0d", e.left, l);
				errors++;
			end
			if (r !== e.right) begin
				$error("right_out mismatch: expected %0d actual %0d", e.right, r);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	gps_in_if in_ch ();
	gps_out_if out_ch ();
	gps_cfg_if cfg_ch ();

	granular_pitch_shifter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	shift_scoreboard sb;
	int idle_cycles;
	int sent;
	bit stall_on;

	always #5 clk = ~clk;

	// Note requests and check results at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.left_in, in_ch.right_in);
			if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.left_out, out_ch.right_out);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("granular_pitch_shifter verification failed");
			$finish;
		end
	end

	// Receiver stall pattern: long free stretches, then phases of random stalls.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_on = ~stall_on;
		out_ch.ready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
	end

	task automatic write_reg(logic [gps_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Let the block drain before touching registers.
	task automatic drain();
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic send_sample(logic signed [SB-1:0] l, logic signed [SB-1:0] r, bit keep);
		in_ch.valid <= 1'b1;
		in_ch.left_in <= l;
		in_ch.right_in <= r;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
		@(negedge clk);
		if (!keep) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	function automatic logic signed [SB-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return {1'b0, {(SB-1){1'b1}}};
			1: return {1'b1, {(SB-1){1'b0}}};
			2: return SB'($signed($urandom_range(0, 2000)) - 1000);
			default: return SB'($urandom);
		endcase
	endfunction

	// Random samples in bursts with gaps.
	task automatic random_burst(int count);
		int burst;
		int k;
		k = 0;
		while (k < count) begin
			burst = $urandom_range(1, 24);
			for (int j = 0; j < burst && k < count; j++) begin
				send_sample(rand_sample(), rand_sample(), j != burst - 1 && k != count - 1);
				k++;
			end
			if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 30)) @(negedge clk);
		end
	endtask

	typedef struct {
		int ratio;
		int mix;
		int win;
		int byp;
	} setting_t;

	setting_t plan [$];

	initial begin
		sb = new();
		sb.clear();
		idle_cycles = 0;
		sent = 0;
		stall_on = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.left_in = '0;
		in_ch.right_in = '0;
		out_ch.ready = 1'b1;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes at reset settings, then short phases on special cases.
		send_sample({1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}, 1'b0);
		send_sample({1'b1, {(SB-1){1'b0}}}, {1'b0, {(SB-1){1'b1}}}, 1'b1);
		send_sample('0, SB'(-1), 1'b0);
		send_sample(SB'(1), {SB{1'b1}}, 1'b0);
		drain();
		write_reg(gps_pkg::CFG_BYPASS_ENABLE, 18'd1);
		send_sample({1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}, 1'b0);
		send_sample(SB'(12345), SB'(-12345), 1'b0);
		drain();
		write_reg(gps_pkg::CFG_BYPASS_ENABLE, 18'd0);
		write_reg(gps_pkg::CFG_RATE_RATIO, 18'h3FFFF);
		write_reg(gps_pkg::CFG_MIX_LEVEL, 18'hFFFF);
		write_reg(gps_pkg::CFG_WINDOW_LENGTH, 18'h1FFF);
		write_reg(3'd7, 18'h15555);
		repeat (6) send_sample(rand_sample(), rand_sample(), 1'b0);
		drain();
		write_reg(gps_pkg::CFG_RATE_RATIO, 18'd0);
		write_reg(gps_pkg::CFG_WINDOW_LENGTH, 18'd0);
		write_reg(gps_pkg::CFG_MIX_LEVEL, 18'd0);
		write_reg(3'd5, 18'h2AAAA);
		repeat (6) send_sample(rand_sample(), rand_sample(), 1'b0);
		drain();
		// Widen the window to its upper bound, at the lowest rate ratio and a fully wet mix.
		write_reg(gps_pkg::CFG_WINDOW_LENGTH, 18'd7992);
		write_reg(gps_pkg::CFG_RATE_RATIO, 18'd32768);
		write_reg(gps_pkg::CFG_MIX_LEVEL, 18'd32768);
		random_burst(40);
		drain();
		write_reg(gps_pkg::CFG_WINDOW_LENGTH, 18'd256);

		plan.push_back('{65536 + 3897, 32768, 2400, 0});
		plan.push_back('{131072, 16384, 256, 0});
		plan.push_back('{32768, 32768, 7992, 0});
		plan.push_back('{65536 - 3678, 20000, 300, 0});
		plan.push_back('{100000, 40000, 1000, 0});
		plan.push_back('{50000, 8000, 8191, 1});
		plan.push_back('{20000, 32768, 100, 0});
		plan.push_back('{140000, 1, 512, 0});
		foreach (plan[p]) begin
			drain();
			write_reg(gps_pkg::CFG_RATE_RATIO, CW'(plan[p].ratio));
			write_reg(gps_pkg::CFG_MIX_LEVEL, CW'(plan[p].mix));
			write_reg(gps_pkg::CFG_WINDOW_LENGTH, CW'(plan[p].win));
			write_reg(gps_pkg::CFG_BYPASS_ENABLE, CW'(plan[p].byp));
			random_burst(100);
		end
		drain();

		$display("Covered %0d samples over %0d register settings, bypass and clamping included.",
			sent, plan.size() + 5);
		$display("Checked %0d results.", sb.checked);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("granular_pitch_shifter verification clean");
		else
			$display("granular_pitch_shifter verification failed");
		$finish;
	end
endmodule

@@ files.f @@
hdl/gps_pkg.sv
hdl/gps_in_if.sv
hdl/gps_out_if.sv
hdl/gps_cfg_if.sv
hdl/gps_divider.sv
hdl/granular_pitch_shifter.sv
dv/tb_granular_pitch_shifter.sv
